// File: hdl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int unsigned HUE_FRAC_BITS = 6;
  localparam int unsigned HUE_W         = 15;
  localparam int unsigned CH_W          = 8;

  localparam int unsigned SECTOR_UNITS  = 60 << HUE_FRAC_BITS;
  localparam int unsigned CIRCLE_UNITS  = 360 << HUE_FRAC_BITS;
  localparam int unsigned REM_W         = $clog2(SECTOR_UNITS + 1);

  // full-scale denominator 255 * sector
  localparam int unsigned DEN           = 255 * SECTOR_UNITS;
  localparam int unsigned DEN_W         = $clog2(DEN + 1);
  localparam int unsigned SP_W          = CH_W + REM_W;
  localparam int unsigned PROD_W        = CH_W + DEN_W;

  // 60 << F = 15 << (F + 2); divide by DEN as shift then divide by 255*15
  localparam int unsigned DIV_SHIFT     = HUE_FRAC_BITS + 2;
  localparam longint unsigned DIV_REST  = 255 * 15;
  localparam int unsigned X_W           = PROD_W - DIV_SHIFT;
  localparam int unsigned RECIP_SHIFT   = 32;
  localparam longint unsigned RECIP     = ((64'd1 << RECIP_SHIFT) + DIV_REST - 1) / DIV_REST;
  localparam int unsigned RECIP_W       = $clog2(RECIP + 1);
  localparam int unsigned MPROD_W       = X_W + RECIP_W;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } h2r_sector_e;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } h2r_adv_t;

endpackage

// File: hdl/h2r_sector.sv
// ----------------------------------------------------------------------------
// h2r_sector
// Splits hue into 60-degree sector and offset within the sector.
// ----------------------------------------------------------------------------
module h2r_sector
  import h2r_pkg::*;
(
  input  logic [HUE_W-1:0] hue_i,
  output h2r_sector_e      sector_o,
  output logic [REM_W-1:0] rem_o
);

  logic [HUE_W-1:0] hue_w;
  logic [HUE_W-1:0] base;

  always_comb begin
    hue_w    = (hue_i >= HUE_W'(CIRCLE_UNITS)) ? '0 : hue_i;
    sector_o = SEC_RED_YEL;
    base     = '0;
    for (int k = 1; k < 6; k++) begin
      if (hue_w >= HUE_W'(k * SECTOR_UNITS)) begin
        sector_o = h2r_sector_e'(3'(k));
        base     = HUE_W'(k * SECTOR_UNITS);
      end
    end
    rem_o = REM_W'(hue_w - base);
  end

endmodule

// File: hdl/h2r_lane.sv
// ----------------------------------------------------------------------------
// h2r_lane
// Pipelined floor(v * (DEN - s * part) / DEN), three register stages.
// ----------------------------------------------------------------------------
module h2r_lane
  import h2r_pkg::*;
(
  input  logic             clk_i,
  input  h2r_adv_t         adv_i,
  input  logic [REM_W-1:0] part_i,
  input  logic [CH_W-1:0]  sat_i,
  input  logic [CH_W-1:0]  val_i,
  output logic [CH_W-1:0]  quot_o
);

  logic [SP_W-1:0]    sp_q, sp_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [MPROD_W-1:0] mprod_q, mprod_d;
  logic [DEN_W-1:0]   diff;
  logic [X_W-1:0]     x;

  always_comb begin
    sp_d    = SP_W'(sat_i) * SP_W'(part_i);
    diff    = DEN_W'(DEN) - DEN_W'(sp_q);
    prod_d  = PROD_W'(val_i) * PROD_W'(diff);
    x       = prod_q[PROD_W-1:DIV_SHIFT];
    mprod_d = MPROD_W'(x) * MPROD_W'(RECIP);
  end

  assign quot_o = mprod_q[RECIP_SHIFT +: CH_W];

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) sp_q    <= sp_d;
    if (adv_i.s3) prod_q  <= prod_d;
    if (adv_i.s4) mprod_q <= mprod_d;
  end

endmodule

// File: hdl/hsv_to_rgb_converter_core.sv
// A color passes the stage 1 to stage 5 registers between input transfer and result valid.
// Throughput: one color per cycle while out_ready_i is high; each stage advances when it is empty or
// its successor advances, so bubbles close up under output back-pressure.
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// HSV to 8-bit RGB converter, five register stages.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
  import h2r_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [HUE_W-1:0] hue_i,
  input  logic [CH_W-1:0]  saturation_i,
  input  logic [CH_W-1:0]  brightness_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CH_W-1:0]  red_o,
  output logic [CH_W-1:0]  green_o,
  output logic [CH_W-1:0]  blue_o
);

  logic [5:1] vld_q, vld_d;
  logic [6:1] rdy;

  h2r_sector_e      sec_d;
  logic [REM_W-1:0] rem_d;

  h2r_sector_e      sec1_q, sec2_q, sec3_q, sec4_q;
  logic [REM_W-1:0] rem1_q;
  logic [CH_W-1:0]  sat1_q;
  logic [CH_W-1:0]  val1_q, val2_q, val3_q, val4_q;
  logic [CH_W-1:0]  red_q, red_d, grn_q, grn_d, blu_q, blu_d;

  logic [CH_W-1:0]  p_w, q_w, t_w;
  logic [REM_W-1:0] t_part;
  h2r_adv_t         adv;

  always_comb begin
    rdy[6] = out_ready_i;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[1] = rdy[1] ? in_valid_i : vld_q[1];
    for (int k = 2; k <= 5; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
    adv.s2 = rdy[2];
    adv.s3 = rdy[3];
    adv.s4 = rdy[4];
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = vld_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  h2r_sector u_sector (
    .hue_i    (hue_i),
    .sector_o (sec_d),
    .rem_o    (rem_d)
  );

  assign t_part = REM_W'(SECTOR_UNITS) - rem1_q;

  h2r_lane u_lane_p (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .part_i (REM_W'(SECTOR_UNITS)),
    .sat_i  (sat1_q),
    .val_i  (val2_q),
    .quot_o (p_w)
  );

  h2r_lane u_lane_q (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .part_i (rem1_q),
    .sat_i  (sat1_q),
    .val_i  (val2_q),
    .quot_o (q_w)
  );

  h2r_lane u_lane_t (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .part_i (t_part),
    .sat_i  (sat1_q),
    .val_i  (val2_q),
    .quot_o (t_w)
  );

  always_comb begin
    case (sec4_q)
      SEC_RED_YEL: begin red_d = val4_q; grn_d = t_w;    blu_d = p_w;    end
      SEC_YEL_GRN: begin red_d = q_w;    grn_d = val4_q; blu_d = p_w;    end
      SEC_GRN_CYN: begin red_d = p_w;    grn_d = val4_q; blu_d = t_w;    end
      SEC_CYN_BLU: begin red_d = p_w;    grn_d = q_w;    blu_d = val4_q; end
      SEC_BLU_MAG: begin red_d = t_w;    grn_d = p_w;    blu_d = val4_q; end
      default:     begin red_d = val4_q; grn_d = p_w;    blu_d = q_w;    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      sec1_q <= sec_d;
      rem1_q <= rem_d;
      sat1_q <= saturation_i;
      val1_q <= brightness_i;
    end
    if (rdy[2]) begin
      sec2_q <= sec1_q;
      val2_q <= val1_q;
    end
    if (rdy[3]) begin
      sec3_q <= sec2_q;
      val3_q <= val2_q;
    end
    if (rdy[4]) begin
      sec4_q <= sec3_q;
      val4_q <= val3_q;
    end
    if (rdy[5]) begin
      red_q <= red_d;
      grn_q <= grn_d;
      blu_q <= blu_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = grn_q;
  assign blue_o  = blu_q;

endmodule
